/* design/bsp_pkg.sv */
// shared types and constants for the beep and siren pattern generator
// no dependencies; compiled first
package bsp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_FREQ   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PUMP_FREQ    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIREN_FREQ   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_ON      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_GAP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIREN_LENGTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SIREN_HALF   = 3'd6;

    // register reset values
    localparam logic [15:0] RST_ALARM_FREQ   = 16'd2000;
    localparam logic [15:0] RST_PUMP_FREQ    = 16'd1000;
    localparam logic [15:0] RST_BEEP_ON      = 16'd100;
    localparam logic [15:0] RST_BEEP_GAP     = 16'd100;
    localparam logic [23:0] RST_SIREN_LENGTH = 24'd10000;
    localparam logic [15:0] RST_SIREN_HALF   = 16'd500;

    localparam logic [15:0] SAT16 = 16'hFFFF;
    localparam logic [23:0] SAT24 = 24'hFF_FFFF;

    // command opcodes
    localparam logic [1:0] OP_TICK        = 2'd0;
    localparam logic [1:0] OP_BEEP        = 2'd1;
    localparam logic [1:0] OP_SIREN_START = 2'd2;
    localparam logic [1:0] OP_SIREN_STOP  = 2'd3;

    // beep source devices
    localparam logic [1:0] DEV_ALARM = 2'd0;
    localparam logic [1:0] DEV_PUMP  = 2'd1;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] device;
        logic       turned_on;
        logic [5:0] pin;
    } cmd_item_t;

    typedef struct packed {
        logic        beep_accepted;
        logic        beep_busy;
        logic        beep_sounding;
        logic [5:0]  beep_pin_out;
        logic [15:0] beep_freq_out;
        logic        siren_active;
        logic        siren_sounding;
        logic [5:0]  siren_pin_out;
    } result_item_t;

endpackage

/* design/bsp_in_if.sv */
// command channel: valid/ready handshake carrying one command beat
// depends on bsp_pkg
interface bsp_in_if;
    import bsp_pkg::*;

    logic      valid;
    logic      ready;
    cmd_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* design/bsp_out_if.sv */
// result channel: valid/ready handshake carrying one result beat
// depends on bsp_pkg
interface bsp_out_if;
    import bsp_pkg::*;

    logic         valid;
    logic         ready;
    result_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* design/beep_and_siren_pattern_generator.sv */
// beep and siren pattern generator, top level
// depends on bsp_pkg, bsp_in_if, bsp_out_if
//
// usage
//   cmd carries one command beat: a 1 ms tick, a beep request, siren start
//   or siren stop. every accepted command beat yields exactly one result beat
//   on result, showing the beep and siren state after that command.
//   the configuration port (cfg_we, cfg_index, cfg_data) writes the tone,
//   timing and length registers; write only while no result is pending.
// timing and throughput
//   a command beat is applied to the state registers at the edge that
//   accepts it; its result is registered in the output register, or in the skid
//   register while that holds a beat. one command beat per cycle is sustained unless cmd.ready is low.
// stall behavior
//   results sit in an output register backed by a one-entry skid register,
//   so one more command is taken while a result waits; cmd.ready drops only
//   when both are full, and nothing is dropped or repeated.
// reset
//   rst_n clears all beep and siren state, empties the result buffer and
//   loads the register defaults (alarm 2000 Hz, pump 1000 Hz, 100 ms beep,
//   100 ms gap, 10000 ms siren length, 500 ms half period).
module beep_and_siren_pattern_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    bsp_in_if.sink                         cmd,
    bsp_out_if.source                      result,
    input  logic                           cfg_we,
    input  logic [bsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bsp_pkg::*;

    // configuration registers (siren tone is not shown on any result field,
    // so its writes are taken and dropped)
    logic [15:0] alarm_freq_reg;
    logic [15:0] pump_freq_reg;
    logic [15:0] beep_on_reg;
    logic [15:0] beep_gap_reg;
    logic [23:0] siren_length_reg;
    logic [15:0] siren_half_reg;

    // beep sequencer state
    logic        beep_running_reg, beep_running_next;
    logic        beep_tone_reg, beep_tone_next;
    logic [1:0]  beeps_done_reg, beeps_done_next;
    logic [1:0]  beeps_wanted_reg, beeps_wanted_next;
    logic [15:0] beep_freq_reg, beep_freq_next;
    logic [5:0]  beep_pin_reg, beep_pin_next;
    logic [15:0] beep_phase_reg, beep_phase_next;

    // siren state
    logic        siren_running_reg, siren_running_next;
    logic        siren_tone_reg, siren_tone_next;
    logic [23:0] siren_elapsed_reg, siren_elapsed_next;
    logic [15:0] siren_toggle_reg, siren_toggle_next;
    logic [5:0]  siren_pin_reg, siren_pin_next;

    // result buffer: output register plus skid register
    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    result_item_t out_data_reg, out_data_next;
    result_item_t skid_data_reg, skid_data_next;

    cmd_item_t    item;
    result_item_t res;
    logic         in_fire;
    logic         out_fire;
    logic         accepted;
    logic [15:0]  phase_inc;
    logic [15:0]  toggle_inc;
    logic [23:0]  elapsed_inc;
    logic [1:0]   done_inc;

    assign item     = cmd.payload;
    assign cmd.ready = !skid_valid_reg;
    assign in_fire  = cmd.valid && cmd.ready;
    assign out_fire = out_valid_reg && result.ready;

    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;

    // saturating counters and the plain beep count increment
    assign phase_inc   = (beep_phase_reg == SAT16) ? SAT16 : beep_phase_reg + 16'd1;
    assign toggle_inc  = (siren_toggle_reg == SAT16) ? SAT16 : siren_toggle_reg + 16'd1;
    assign elapsed_inc = (siren_elapsed_reg == SAT24) ? SAT24 : siren_elapsed_reg + 24'd1;
    assign done_inc    = beeps_done_reg + 2'd1;

    // command decode and next state
    always_comb
    begin
        beep_running_next  = beep_running_reg;
        beep_tone_next     = beep_tone_reg;
        beeps_done_next    = beeps_done_reg;
        beeps_wanted_next  = beeps_wanted_reg;
        beep_freq_next     = beep_freq_reg;
        beep_pin_next      = beep_pin_reg;
        beep_phase_next    = beep_phase_reg;
        siren_running_next = siren_running_reg;
        siren_tone_next    = siren_tone_reg;
        siren_elapsed_next = siren_elapsed_reg;
        siren_toggle_next  = siren_toggle_reg;
        siren_pin_next     = siren_pin_reg;
        accepted           = 1'b0;

        case (item.op)
            OP_TICK:
            begin
                // beep step runs before the siren step
                if (beep_running_reg)
                begin
                    if (beep_tone_reg)
                    begin
                        if (phase_inc >= beep_on_reg)
                        begin
                            beep_tone_next  = 1'b0;
                            beep_phase_next = 16'd0;
                            beeps_done_next = done_inc;
                            if (done_inc >= beeps_wanted_reg)
                            begin
                                beep_running_next = 1'b0;
                            end
                        end
                        else
                        begin
                            beep_phase_next = phase_inc;
                        end
                    end
                    else if (beeps_done_reg == 2'd0)
                    begin
                        // first tick after the request starts the first beep
                        beep_tone_next  = 1'b1;
                        beep_phase_next = 16'd0;
                    end
                    else if (phase_inc >= beep_gap_reg)
                    begin
                        beep_tone_next  = 1'b1;
                        beep_phase_next = 16'd0;
                    end
                    else
                    begin
                        beep_phase_next = phase_inc;
                    end
                end

                siren_pin_next = item.pin;
                if (siren_running_reg)
                begin
                    siren_elapsed_next = elapsed_inc;
                    if (elapsed_inc >= siren_length_reg)
                    begin
                        siren_running_next = 1'b0;
                        siren_tone_next    = 1'b0;
                    end
                    else if (toggle_inc >= siren_half_reg)
                    begin
                        siren_tone_next   = !siren_tone_reg;
                        siren_toggle_next = 16'd0;
                    end
                    else
                    begin
                        siren_toggle_next = toggle_inc;
                    end
                end
            end
            OP_BEEP:
            begin
                if (!siren_running_reg && !beep_running_reg &&
                    (item.device == DEV_ALARM || item.device == DEV_PUMP))
                begin
                    if (item.device == DEV_ALARM)
                    begin
                        beep_freq_next    = alarm_freq_reg;
                        beeps_wanted_next = item.turned_on ? 2'd2 : 2'd1;
                    end
                    else
                    begin
                        beep_freq_next    = pump_freq_reg;
                        beeps_wanted_next = item.turned_on ? 2'd1 : 2'd2;
                    end
                    beep_running_next = 1'b1;
                    beep_pin_next     = item.pin;
                    beeps_done_next   = 2'd0;
                    beep_tone_next    = 1'b0;
                    beep_phase_next   = 16'd0;
                    accepted          = 1'b1;
                end
            end
            OP_SIREN_START:
            begin
                // toggle counter starts saturated so the first tick turns the tone on, unless the siren ends on it
                if (!siren_running_reg)
                begin
                    siren_running_next = 1'b1;
                    siren_elapsed_next = 24'd0;
                    siren_toggle_next  = SAT16;
                    siren_tone_next    = 1'b0;
                end
            end
            OP_SIREN_STOP:
            begin
                siren_running_next = 1'b0;
                siren_tone_next    = 1'b0;
                siren_pin_next     = item.pin;
            end
            default:
            begin
                siren_pin_next = siren_pin_reg;
            end
        endcase
    end

    // result built from the post-command state
    always_comb
    begin
        res.beep_accepted  = accepted;
        res.beep_busy      = beep_running_next;
        res.beep_sounding  = beep_tone_next;
        res.beep_pin_out   = beep_pin_next;
        res.beep_freq_out  = beep_freq_next;
        res.siren_active   = siren_running_next;
        res.siren_sounding = siren_tone_next;
        res.siren_pin_out  = siren_pin_next;
    end

    // result buffer control
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (in_fire)
        begin
            if (!out_valid_next)
            begin
                out_data_next  = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_freq_reg   <= RST_ALARM_FREQ;
            pump_freq_reg    <= RST_PUMP_FREQ;
            beep_on_reg      <= RST_BEEP_ON;
            beep_gap_reg     <= RST_BEEP_GAP;
            siren_length_reg <= RST_SIREN_LENGTH;
            siren_half_reg   <= RST_SIREN_HALF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ALARM_FREQ:   alarm_freq_reg   <= cfg_data[15:0];
                REG_PUMP_FREQ:    pump_freq_reg    <= cfg_data[15:0];
                REG_SIREN_FREQ:   alarm_freq_reg   <= alarm_freq_reg;
                REG_BEEP_ON:      beep_on_reg      <= cfg_data[15:0];
                REG_BEEP_GAP:     beep_gap_reg     <= cfg_data[15:0];
                REG_SIREN_LENGTH: siren_length_reg <= cfg_data;
                REG_SIREN_HALF:   siren_half_reg   <= cfg_data[15:0];
                default:          siren_half_reg   <= siren_half_reg;
            endcase
        end
    end

    // beep and siren state, advanced on each accepted command beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beep_running_reg  <= 1'b0;
            beep_tone_reg     <= 1'b0;
            beeps_done_reg    <= 2'd0;
            beeps_wanted_reg  <= 2'd0;
            beep_freq_reg     <= 16'd0;
            beep_pin_reg      <= 6'd0;
            beep_phase_reg    <= 16'd0;
            siren_running_reg <= 1'b0;
            siren_tone_reg    <= 1'b0;
            siren_elapsed_reg <= 24'd0;
            siren_toggle_reg  <= 16'd0;
            siren_pin_reg     <= 6'd0;
        end
        else if (in_fire)
        begin
            beep_running_reg  <= beep_running_next;
            beep_tone_reg     <= beep_tone_next;
            beeps_done_reg    <= beeps_done_next;
            beeps_wanted_reg  <= beeps_wanted_next;
            beep_freq_reg     <= beep_freq_next;
            beep_pin_reg      <= beep_pin_next;
            beep_phase_reg    <= beep_phase_next;
            siren_running_reg <= siren_running_next;
            siren_tone_reg    <= siren_tone_next;
            siren_elapsed_reg <= siren_elapsed_next;
            siren_toggle_reg  <= siren_toggle_next;
            siren_pin_reg     <= siren_pin_next;
        end
    end

    // result buffer valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // result buffer payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef SYNTHESIS
    // skid entry is only ever filled behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a beat while output register is empty");

    // a running sequence has fewer finished beeps than requested
    a_beep_count: assert property (@(posedge clk) disable iff (!rst_n)
        beep_running_reg |-> (beeps_done_reg < beeps_wanted_reg))
        else $error("beep sequence running past its beep count");

    // beep tone only sounds inside a running sequence
    a_beep_tone: assert property (@(posedge clk) disable iff (!rst_n)
        beep_tone_reg |-> beep_running_reg)
        else $error("beep tone driven with no sequence running");

    // siren tone only sounds while the siren runs
    a_siren_tone: assert property (@(posedge clk) disable iff (!rst_n)
        siren_tone_reg |-> siren_running_reg)
        else $error("siren tone driven while siren is stopped");

    // after an accepted command the output register holds a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted command produced no pending result");
`endif

endmodule

/* bench/tb.sv */
// self-checking bench for the beep and siren pattern generator
// drives command beats and register writes, predicts every result beat
// depends on bsp_pkg, bsp_in_if, bsp_out_if and the design top level
`timescale 1ns / 100ps

module tb;
    import bsp_pkg::*;

    // extra codes the package leaves out
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [1:0] DEV_SPARE_LO = 2'd2;
    localparam logic [1:0] DEV_SPARE_HI = 2'd3;

    // quiet cycles (nothing moving on either channel) before giving up
    localparam int unsigned QUIET_LIMIT = 400;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bsp_in_if  cmd_if ();
    bsp_out_if res_if ();

    beep_and_siren_pattern_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if.sink),
        .result    (res_if.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // register shadow, loaded with the reset values (the siren tone has none)
    // ------------------------------------------------------------------
    logic [15:0] alarm_hz    = RST_ALARM_FREQ;
    logic [15:0] pump_hz     = RST_PUMP_FREQ;
    logic [15:0] siren_hz    = 16'd2500;   // not held by the block, never visible
    logic [15:0] beep_on_len = RST_BEEP_ON;
    logic [15:0] beep_gap_len = RST_BEEP_GAP;
    logic [23:0] siren_len   = RST_SIREN_LENGTH;
    logic [15:0] siren_half  = RST_SIREN_HALF;

    // ------------------------------------------------------------------
    // buzzer state as the bench expects it, all zero after reset
    // ------------------------------------------------------------------
    bit          beep_run     = 1'b0;
    bit          beep_tone    = 1'b0;
    logic [1:0]  beeps_played = '0;
    logic [1:0]  beeps_owed   = '0;
    logic [15:0] beep_hz_held = '0;
    logic [5:0]  beep_pin     = '0;
    logic [15:0] beep_ticks   = '0;
    bit          siren_run    = 1'b0;
    bit          siren_tone   = 1'b0;
    logic [23:0] siren_ticks  = '0;
    logic [15:0] toggle_ticks = '0;
    logic [5:0]  siren_pin    = '0;

    result_item_t expected_q[$];   // one result beat per accepted command
    int unsigned  fail_count  = 0;
    int unsigned  quiet_cycles = 0;
    bit           allow_idle  = 1'b1;

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic logic [15:0] sat_inc16(logic [15:0] v);
        return (v == SAT16) ? v : v + 16'd1;
    endfunction

    // apply one command to the expected state, return the result beat
    function automatic result_item_t predict_result(cmd_item_t c);
        result_item_t r;
        bit taken;
        taken = 1'b0;
        case (c.op)
            OP_TICK:
            begin
                // beep step first
                if (beep_run)
                begin
                    if (beep_tone)
                    begin
                        beep_ticks = sat_inc16(beep_ticks);
                        if (beep_ticks >= beep_on_len)
                        begin
                            beep_tone    = 1'b0;
                            beep_ticks   = '0;
                            beeps_played = beeps_played + 2'd1;
                            if (beeps_played >= beeps_owed)
                                beep_run = 1'b0;
                        end
                    end
                    else if (beeps_played == 2'd0)
                    begin
                        // first tick after the request starts the tone
                        beep_tone  = 1'b1;
                        beep_ticks = '0;
                    end
                    else
                    begin
                        // silent gap between beeps, at least one tick
                        beep_ticks = sat_inc16(beep_ticks);
                        if (beep_ticks >= beep_gap_len)
                        begin
                            beep_tone  = 1'b1;
                            beep_ticks = '0;
                        end
                    end
                end
                // then the siren step
                siren_pin = c.pin;
                if (siren_run)
                begin
                    siren_ticks = (siren_ticks == SAT24) ? SAT24 : siren_ticks + 24'd1;
                    if (siren_ticks >= siren_len)
                    begin
                        // siren runs out by itself
                        siren_run  = 1'b0;
                        siren_tone = 1'b0;
                    end
                    else
                    begin
                        toggle_ticks = sat_inc16(toggle_ticks);
                        if (toggle_ticks >= siren_half)
                        begin
                            siren_tone   = !siren_tone;
                            toggle_ticks = '0;
                        end
                    end
                end
            end
            OP_BEEP:
            begin
                // only taken when both sides are quiet and the device is real
                if (!siren_run && !beep_run &&
                    (c.device == DEV_ALARM || c.device == DEV_PUMP))
                begin
                    if (c.device == DEV_ALARM)
                    begin
                        beep_hz_held = alarm_hz;
                        beeps_owed   = c.turned_on ? 2'd2 : 2'd1;
                    end
                    else
                    begin
                        beep_hz_held = pump_hz;
                        beeps_owed   = c.turned_on ? 2'd1 : 2'd2;
                    end
                    beep_run     = 1'b1;
                    beep_pin     = c.pin;
                    beeps_played = '0;
                    beep_tone    = 1'b0;
                    beep_ticks   = '0;
                    taken        = 1'b1;
                end
            end
            OP_SIREN_START:
            begin
                // a start while running is ignored; the preset toggle count
                // makes the first tick turn the tone on unless the siren runs out on it
                if (!siren_run)
                begin
                    siren_run    = 1'b1;
                    siren_ticks  = '0;
                    toggle_ticks = SAT16;
                    siren_tone   = 1'b0;
                end
            end
            default:
            begin
                // stop always clears the siren, idle or not
                siren_run  = 1'b0;
                siren_tone = 1'b0;
                siren_pin  = c.pin;
            end
        endcase
        r.beep_accepted  = taken;
        r.beep_busy      = beep_run;
        r.beep_sounding  = beep_tone;
        r.beep_pin_out   = beep_pin;
        r.beep_freq_out  = beep_hz_held;
        r.siren_active   = siren_run;
        r.siren_sounding = siren_tone;
        r.siren_pin_out  = siren_pin;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result side: random stall bursts on ready, checker on every beat
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_if.ready <= 1'b1;
                if (allow_idle && $urandom_range(0, 11) == 0)
                    stall_left = $urandom_range(1, 10);
            end
        end
    end

    function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_beat
        result_item_t want;
        result_item_t got;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got = res_if.payload;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, got %0h", $time, got);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("beep_accepted",  24'(want.beep_accepted),  24'(got.beep_accepted));
                check_field("beep_busy",      24'(want.beep_busy),      24'(got.beep_busy));
                check_field("beep_sounding",  24'(want.beep_sounding),  24'(got.beep_sounding));
                check_field("beep_pin_out",   24'(want.beep_pin_out),   24'(got.beep_pin_out));
                check_field("beep_freq_out",  24'(want.beep_freq_out),  24'(got.beep_freq_out));
                check_field("siren_active",   24'(want.siren_active),   24'(got.siren_active));
                check_field("siren_sounding", 24'(want.siren_sounding),
                            24'(got.siren_sounding));
                check_field("siren_pin_out",  24'(want.siren_pin_out),  24'(got.siren_pin_out));
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run when nothing moves for too long
    // ------------------------------------------------------------------
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // command side helpers
    // ------------------------------------------------------------------
    function automatic cmd_item_t make_cmd(logic [1:0] op, logic [1:0] dev, logic on,
                                           logic [5:0] pin);
        cmd_item_t c;
        c.op        = op;
        c.device    = dev;
        c.turned_on = on;
        c.pin       = pin;
        return c;
    endfunction

    // send one command beat; valid stays high into the next beat unless
    // an idle burst comes first
    task automatic send_cmd(input cmd_item_t c);
        if (allow_idle && $urandom_range(0, 7) == 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.payload <= c;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        expected_q.push_back(predict_result(c));
    endtask

    // drop valid and wait until every expected beat has come back
    task automatic settle_results();
        cmd_if.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        // narrow registers keep only their low bits
        case (idx)
            REG_ALARM_FREQ:   alarm_hz     = data[15:0];
            REG_PUMP_FREQ:    pump_hz      = data[15:0];
            REG_SIREN_FREQ:   siren_hz     = data[15:0];
            REG_BEEP_ON:      beep_on_len  = data[15:0];
            REG_BEEP_GAP:     beep_gap_len = data[15:0];
            REG_SIREN_LENGTH: siren_len    = data;
            REG_SIREN_HALF:   siren_half   = data[15:0];
            default:          ;
        endcase
    endtask

    // full register set, written once the block has gone quiet
    task automatic load_config(input logic [23:0] alarm, input logic [23:0] pump,
                               input logic [23:0] siren, input logic [23:0] on_len,
                               input logic [23:0] gap_len, input logic [23:0] length,
                               input logic [23:0] half);
        settle_results();
        write_reg(REG_ALARM_FREQ, alarm);
        write_reg(REG_PUMP_FREQ, pump);
        write_reg(REG_SIREN_FREQ, siren);
        write_reg(REG_BEEP_ON, on_len);
        write_reg(REG_BEEP_GAP, gap_len);
        write_reg(REG_SIREN_LENGTH, length);
        write_reg(REG_SIREN_HALF, half);
    endtask

    // random upper byte on top of a 16-bit value, to show it is dropped
    function automatic logic [23:0] with_junk(logic [15:0] v);
        return {8'($urandom), v};
    endfunction

    // mostly ticks and beep requests so sequences play out in full,
    // with some siren events and invalid devices mixed in
    task automatic run_random_traffic(input int unsigned count);
        cmd_item_t c;
        int unsigned roll;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            c = make_cmd(OP_TICK, 2'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         6'($urandom_range(0, 63)));
            if (roll >= 58 && roll < 82)
            begin
                c.op = OP_BEEP;
                if ($urandom_range(0, 9) == 0)
                    c.device = 2'($urandom_range(2, 3));
            end
            else if (roll >= 82 && roll < 93)
                c.op = OP_SIREN_START;
            else if (roll >= 93)
                c.op = OP_SIREN_STOP;
            send_cmd(c);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values: pump then alarm beeps at the default timing,
    // refusals while busy, siren start and stop around a running beep
    task automatic test_reset_defaults();
        send_cmd(make_cmd(OP_TICK, DEV_ALARM, 1'b0, 6'd63));
        send_cmd(make_cmd(OP_BEEP, DEV_PUMP, 1'b1, 6'd63));
        send_cmd(make_cmd(OP_BEEP, DEV_ALARM, 1'b1, 6'd5));       // busy
        send_cmd(make_cmd(OP_BEEP, DEV_SPARE_HI, 1'b1, 6'd5));    // bad device
        send_cmd(make_cmd(OP_SIREN_START, DEV_ALARM, 1'b0, 6'd0)); // beep keeps going
        send_cmd(make_cmd(OP_SIREN_START, DEV_ALARM, 1'b0, 6'd0)); // ignored
        send_cmd(make_cmd(OP_TICK, DEV_ALARM, 1'b0, 6'd0));
        send_cmd(make_cmd(OP_SIREN_STOP, DEV_ALARM, 1'b0, 6'd21));
        send_cmd(make_cmd(OP_SIREN_STOP, DEV_ALARM, 1'b0, 6'd42)); // stop while idle
        while (beep_run)
            send_cmd(make_cmd(OP_TICK, DEV_ALARM, 1'b0, 6'($urandom_range(0, 63))));
        send_cmd(make_cmd(OP_BEEP, DEV_ALARM, 1'b0, 6'd0));
        while (beep_run)
            send_cmd(make_cmd(OP_TICK, DEV_ALARM, 1'b0, 6'($urandom_range(0, 63))));
    endtask

    // shortest timing and extreme tones: gap of zero, one-tick beeps,
    // siren that toggles every tick and ends after three
    task automatic test_edge_timing();
        load_config(24'hFF_FFFF, 24'h00_0000, 24'h00_FFFF, 24'd1, 24'd0, 24'd3, 24'd1);
        write_reg(REG_UNUSED, 24'hFF_FFFF);  // no register behind this index
        send_cmd(make_cmd(OP_BEEP, DEV_SPARE_LO, 1'b1, 6'd63));
        send_cmd(make_cmd(OP_BEEP, DEV_ALARM, 1'b1, 6'd63));
        repeat (5)
            send_cmd(make_cmd(OP_TICK, DEV_ALARM, 1'b0, 6'd63));
        send_cmd(make_cmd(OP_SIREN_START, DEV_ALARM, 1'b0, 6'd0));
        send_cmd(make_cmd(OP_BEEP, DEV_PUMP, 1'b0, 6'd0));        // siren blocks it
        repeat (3)
            send_cmd(make_cmd(OP_TICK, DEV_ALARM, 1'b0, 6'd0));
        send_cmd(make_cmd(OP_BEEP, DEV_PUMP, 1'b0, 6'd0));
        send_cmd(make_cmd(OP_SIREN_START, DEV_ALARM, 1'b0, 6'd0));
        send_cmd(make_cmd(OP_SIREN_START, DEV_ALARM, 1'b0, 6'd63));
        repeat (4)
            send_cmd(make_cmd(OP_TICK, DEV_ALARM, 1'b1, 6'd63));
        send_cmd(make_cmd(OP_SIREN_STOP, DEV_ALARM, 1'b0, 6'd63));
        send_cmd(make_cmd(OP_BEEP, DEV_SPARE_HI, 1'b0, 6'd63));
    endtask

    // short random timing, junk in the upper bits of narrow registers
    task automatic test_random_short();
        load_config(24'($urandom), 24'($urandom), 24'($urandom),
                    with_junk(16'($urandom_range(1, 6))), with_junk(16'($urandom_range(0, 6))),
                    24'($urandom_range(1, 40)), with_junk(16'($urandom_range(1, 8))));
        run_random_traffic(180);
    endtask

    // largest values: the first beep never ends, the siren toggles once
    task automatic test_random_max();
        load_config(24'h00_FFFF, 24'h00_FFFF, 24'h00_FFFF, 24'h00_FFFF, 24'h00_FFFF,
                    24'hFF_FFFF, 24'h00_FFFF);
        run_random_traffic(100);
    endtask

    // smallest values: siren gone after one tick, zero tones
    task automatic test_random_min();
        load_config(24'h00_0000, 24'h00_0000, 24'h00_0000, 24'd1, 24'd0, 24'd1, 24'd1);
        run_random_traffic(160);
    endtask

    // medium timing at full rate, no idling on either side
    task automatic test_random_full_rate();
        load_config(24'($urandom), 24'($urandom), 24'($urandom),
                    24'($urandom_range(2, 20)), 24'($urandom_range(0, 20)),
                    24'($urandom_range(5, 200)), 24'($urandom_range(1, 30)));
        allow_idle = 1'b0;
        run_random_traffic(180);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        cmd_if.valid   <= 1'b0;
        cmd_if.payload <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_edge_timing();
        test_random_short();
        test_random_max();
        test_random_min();
        test_random_full_rate();

        // last results, then a wait for anything stray
        settle_results();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
design/bsp_pkg.sv
design/bsp_in_if.sv
design/bsp_out_if.sv
design/beep_and_siren_pattern_generator.sv
bench/tb.sv
